// ===== rtl/bitmask_subset_pair_finder_defines.svh =====
// assertion macros for the subset pair finder
`ifndef BITMASK_SUBSET_PAIR_FINDER_DEFINES_SVH
`define BITMASK_SUBSET_PAIR_FINDER_DEFINES_SVH

`ifndef SYNTH

`define BSPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BSPF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BSPF_ASSERT(lbl, prop, msg)

`define BSPF_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/bspf_pkg.sv =====
// shared types, constants and helpers for the subset pair finder
package bspf_pkg;

    localparam int MASK_W = 64;
    localparam int SLOT_W = 6;
    localparam int TGT_W = 6;
    localparam int CNT_W = 7;
    localparam int SRC_W = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam int DEF_TARGETS = 64;
    localparam int DEF_MASK_BYTES = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_TARGET_COUNT = 1'b0;

    typedef struct packed {
        logic hit;
        logic equal;
    } bspf_cmp_t;

    function automatic logic [MASK_W-1:0] width_mask(input int bytes);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int p = 0; p < MASK_W / 8; p++)
        begin
            m[8*p +: 8] = (p < bytes) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/bspf_table.sv =====
// target mask memory, one write port and one registered read port
module bspf_table #(
    parameter int TARGETS = bspf_pkg::DEF_TARGETS,
    parameter int AW = 6
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [bspf_pkg::MASK_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [bspf_pkg::MASK_W-1:0] rd_data
);
    import bspf_pkg::*;

    logic [MASK_W-1:0] mem [TARGETS];
    logic [MASK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bspf_cmp.sv =====
// containment and equality compare of source against one target
module bspf_cmp #(
    parameter int MASK_BYTES = bspf_pkg::DEF_MASK_BYTES
) (
    input  logic [bspf_pkg::MASK_W-1:0] src_mask,
    input  logic [bspf_pkg::MASK_W-1:0] tgt_mask,
    output bspf_pkg::bspf_cmp_t         res
);
    import bspf_pkg::*;

    localparam logic [MASK_W-1:0] WMASK = width_mask(MASK_BYTES);

    logic [MASK_W-1:0] tgt;
    logic [MASK_W-1:0] src;

    assign tgt = tgt_mask & WMASK;
    assign src = src_mask & WMASK;

    always_comb
    begin
        res.hit = ((src & ~tgt) == '0);
        res.equal = ((src ^ tgt) == '0);
    end

endmodule

// ===== rtl/bspf_ctrl.sv =====
// scan sequencer, query counter and result register
`include "bitmask_subset_pair_finder_defines.svh"

module bspf_ctrl #(
    parameter int TARGETS = bspf_pkg::DEF_TARGETS,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        cmd,
    input  logic [bspf_pkg::SLOT_W-1:0] slot,
    input  logic [bspf_pkg::MASK_W-1:0] mask,
    input  logic [bspf_pkg::CNT_W-1:0]  target_count,
    output logic                        busy,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output logic [bspf_pkg::MASK_W-1:0] src_mask,
    input  bspf_pkg::bspf_cmp_t         cmp_res,
    output logic                        valid,
    output logic [bspf_pkg::SRC_W-1:0]  source_number,
    output logic [bspf_pkg::TGT_W-1:0]  target_number,
    output logic                        is_equal,
    output logic                        found,
    output logic                        last
);
    import bspf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    localparam logic [CNT_W-1:0] TGT_LIM = CNT_W'(TARGETS);

    state_t             state_reg, state_next;
    logic [SRC_W-1:0]   qcnt_reg, qcnt_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [MASK_W-1:0]  src_mask_reg, src_mask_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               pend_eq_reg, pend_eq_next;
    logic               valid_reg, valid_next;
    logic [SRC_W-1:0]   source_number_reg, source_number_next;
    logic [TGT_W-1:0]   target_number_reg, target_number_next;
    logic               is_equal_reg, is_equal_next;
    logic               found_reg, found_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               query_go;
    logic [CNT_W-1:0]   n_lim;

    assign accept = start && (state_reg == ST_IDLE);
    assign query_go = accept && (cmd == CMD_QUERY);
    assign n_lim = (target_count > TGT_LIM) ? TGT_LIM : target_count;

    assign busy = (state_reg != ST_IDLE);
    assign wr_en = accept && (cmd == CMD_LOAD) && ({1'b0, slot} < TGT_LIM);
    assign wr_addr = slot[AW-1:0];
    assign rd_en = (state_reg == ST_SCAN);
    assign rd_addr = idx_reg;
    assign src_mask = src_mask_reg;

    always_comb
    begin
        state_next = state_reg;
        qcnt_next = qcnt_reg;
        src_next = src_reg;
        src_mask_next = src_mask_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next = pend_idx_reg;
        pend_eq_next = pend_eq_reg;
        valid_next = 1'b0;
        source_number_next = source_number_reg;
        target_number_next = target_number_reg;
        is_equal_next = is_equal_reg;
        found_next = found_reg;
        last_next = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    src_next = qcnt_reg;
                    qcnt_next = qcnt_reg + SRC_W'(1);
                    src_mask_next = mask;
                    n_next = n_lim[CW-1:0];
                    idx_next = '0;
                    pend_valid_next = 1'b0;
                    state_next = (n_lim == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_valid_next = 1'b1;
                if (CW'(idx_reg) == n_reg - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                valid_next = 1'b1;
                last_next = 1'b1;
                source_number_next = src_reg;
                found_next = pend_valid_reg;
                target_number_next = pend_valid_reg ? TGT_W'(pend_idx_reg) : '0;
                is_equal_next = pend_valid_reg && pend_eq_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new hit pushes the held one out, the held one is the last candidate
        if (chk_valid_reg && cmp_res.hit)
        begin
            if (pend_valid_reg)
            begin
                valid_next = 1'b1;
                last_next = 1'b0;
                found_next = 1'b1;
                source_number_next = src_reg;
                target_number_next = TGT_W'(pend_idx_reg);
                is_equal_next = pend_eq_reg;
            end
            pend_valid_next = 1'b1;
            pend_idx_next = chk_idx_reg;
            pend_eq_next = cmp_res.equal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            qcnt_reg <= '0;
            src_reg <= '0;
            src_mask_reg <= '0;
            n_reg <= '0;
            idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg <= '0;
            pend_eq_reg <= 1'b0;
            valid_reg <= 1'b0;
            source_number_reg <= '0;
            target_number_reg <= '0;
            is_equal_reg <= 1'b0;
            found_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            qcnt_reg <= qcnt_next;
            src_reg <= src_next;
            src_mask_reg <= src_mask_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg <= chk_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg <= pend_idx_next;
            pend_eq_reg <= pend_eq_next;
            valid_reg <= valid_next;
            source_number_reg <= source_number_next;
            target_number_reg <= target_number_next;
            is_equal_reg <= is_equal_next;
            found_reg <= found_next;
            last_reg <= last_next;
        end
    end

    assign valid = valid_reg;
    assign source_number = source_number_reg;
    assign target_number = target_number_reg;
    assign is_equal = is_equal_reg;
    assign found = found_reg;
    assign last = last_reg;

    `BSPF_ASSERT(a_result_in_query, !valid_reg || $past(state_reg != ST_IDLE), "result outside query")
    `BSPF_ASSERT(a_last_ends_query, !(valid_reg && last_reg) || (state_reg == ST_IDLE), "last result while scanning")
    `BSPF_ASSERT(a_miss_is_last, !(valid_reg && !found_reg) || last_reg, "not-found result not last")
    `BSPF_ASSERT_NEXT(a_query_busy, query_go, busy, "query request did not start scan")
    `BSPF_ASSERT(a_hit_in_range, !(valid_reg && found_reg) || ((TGT_W+1)'(target_number_reg) < (TGT_W+1)'(n_reg)), "match index beyond table in use")

endmodule

// ===== rtl/bitmask_subset_pair_finder.sv =====
// top level: apb register, target table, compare unit and scan sequencer
//
// requests come in on start/cmd/mask/slot and are taken when start is high
// and busy is low. a load request (cmd 0) writes mask into table entry slot
// and gives no result; slots at or above TARGETS are dropped.
// a query request (cmd 1) reads the table entries 0 .. n-1 one per cycle
// through the single table read port and checks each in the shared compare
// unit, n being target_count limited to TARGETS. busy stays high from the
// taking edge through the scan, drain and flush states; with n zero the
// scan and drain states are skipped. the last result of a query shows as
// busy falls again.
// a match is held one step so the final one can carry last; a query with
// no match gives one result with found low and last high.
// results appear for one cycle each with valid high; the receiver cannot
// stall them. target_count is to be written through the apb port while
// idle, not enforced by the block. reset clears the sequencer, the query
// counter and target_count; table contents are undefined until loaded.
module bitmask_subset_pair_finder #(
    parameter int TARGETS = bspf_pkg::DEF_TARGETS,
    parameter int MASK_BYTES = bspf_pkg::DEF_MASK_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bspf_pkg::ADDR_W-1:0] paddr,
    input  logic [bspf_pkg::DATA_W-1:0] pwdata,
    output logic [bspf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [bspf_pkg::MASK_W-1:0] mask,
    input  logic [bspf_pkg::SLOT_W-1:0] slot,
    output logic                        valid,
    output logic [bspf_pkg::SRC_W-1:0]  source_number,
    output logic [bspf_pkg::TGT_W-1:0]  target_number,
    output logic                        is_equal,
    output logic                        found,
    output logic                        last
);
    import bspf_pkg::*;

    localparam int AW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam int CW = $clog2(TARGETS + 1);
    localparam logic [MASK_W-1:0] WMASK = width_mask(MASK_BYTES);

    logic [CNT_W-1:0]  target_count_reg;
    logic              cfg_wr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [MASK_W-1:0] rd_data;
    logic [MASK_W-1:0] src_mask;
    bspf_cmp_t         cmp_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == REG_TARGET_COUNT);
    assign prdata = (paddr[ADDR_W-1] == REG_TARGET_COUNT) ? DATA_W'(target_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            target_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    bspf_table #(
        .TARGETS (TARGETS),
        .AW      (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (mask & WMASK),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bspf_cmp #(
        .MASK_BYTES (MASK_BYTES)
    ) u_cmp (
        .src_mask (src_mask),
        .tgt_mask (rd_data),
        .res      (cmp_res)
    );

    bspf_ctrl #(
        .TARGETS (TARGETS),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .slot          (slot),
        .mask          (mask & WMASK),
        .target_count  (target_count_reg),
        .busy          (busy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .src_mask      (src_mask),
        .cmp_res       (cmp_res),
        .valid         (valid),
        .source_number (source_number),
        .target_number (target_number),
        .is_equal      (is_equal),
        .found         (found),
        .last          (last)
    );

endmodule
